@@ hdl/pcpl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpl_pkg
// Shared constants, register indexes and controller-to-datapath command types
// for the phase current Clarke/Park/low-pass block.
// ----------------------------------------------------------------------------
package pcpl_pkg;

  // default parameter values
  localparam int ADC_BITS_DEF         = 12;
  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int CURRENT_WIDTH_DEF    = 16;

  // fixed field widths
  localparam int ANGLE_W    = 16;
  localparam int OUT_W      = 16;
  localparam int BIAS_W     = 12;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_COUNTS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPS_PER_COUNT = 8'd1;

  // register reset values
  localparam logic [BIAS_W-1:0]  BIAS_RESET  = 12'd2048;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // Q15 constants
  localparam int COEF_W = 17;
  localparam logic signed [COEF_W-1:0] INV_SQRT3_Q15     = 17'sd18919;
  localparam logic signed [COEF_W-1:0] TWO_INV_SQRT3_Q15 = 17'sd37837;
  localparam logic signed [COEF_W-1:0] LPF_OLD_Q15       = 17'sd29491;
  localparam logic signed [COEF_W-1:0] LPF_NEW_Q15       = 17'sd3277;

  // multiplier a-operand select
  localparam logic [3:0] A_DIFF_A = 4'd0;
  localparam logic [3:0] A_DIFF_B = 4'd1;
  localparam logic [3:0] A_IA     = 4'd2;
  localparam logic [3:0] A_IB     = 4'd3;
  localparam logic [3:0] A_BETA   = 4'd4;
  localparam logic [3:0] A_D      = 4'd5;
  localparam logic [3:0] A_Q      = 4'd6;
  localparam logic [3:0] A_FD     = 4'd7;
  localparam logic [3:0] A_FQ     = 4'd8;

  // multiplier b-operand select
  localparam logic [2:0] B_SCALE  = 3'd0;
  localparam logic [2:0] B_INV    = 3'd1;
  localparam logic [2:0] B_TWOINV = 3'd2;
  localparam logic [2:0] B_COS    = 3'd3;
  localparam logic [2:0] B_SIN    = 3'd4;
  localparam logic [2:0] B_OLD    = 3'd5;
  localparam logic [2:0] B_NEW    = 3'd6;

  // accumulator operation
  localparam logic [1:0] ACC_LOAD     = 2'd0;
  localparam logic [1:0] ACC_LOAD_RND = 2'd1;
  localparam logic [1:0] ACC_ADD      = 2'd2;
  localparam logic [1:0] ACC_SUB      = 2'd3;

  // write-back destination
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_IA   = 3'd1;
  localparam logic [2:0] WB_IB   = 3'd2;
  localparam logic [2:0] WB_BETA = 3'd3;
  localparam logic [2:0] WB_D    = 3'd4;
  localparam logic [2:0] WB_Q    = 3'd5;
  localparam logic [2:0] WB_FD   = 3'd6;
  localparam logic [2:0] WB_FQ   = 3'd7;

  // one multiply-accumulate step
  typedef struct packed {
    logic       issue;
    logic [3:0] a_sel;
    logic [2:0] b_sel;
    logic [1:0] acc_op;
    logic [2:0] wb_dst;
  } pcpl_op_t;

  // controller commands
  typedef struct packed {
    logic     capture;
    logic     load_out;
    pcpl_op_t op;
  } pcpl_cmd_t;

  // configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } pcpl_cfg_wr_t;

endpackage

@@ hdl/pcpl_if.sv @@
// ----------------------------------------------------------------------------
// pcpl channel interfaces
// Valid/ready channels for sample input, current output and register writes.
// ----------------------------------------------------------------------------
interface pcpl_in_if
  import pcpl_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_phase_a;
  logic [ADC_BITS-1:0] adc_phase_b;
  logic [ANGLE_W-1:0]  rotor_angle;

  modport source (output valid, adc_phase_a, adc_phase_b, rotor_angle, input ready);
  modport sink   (input valid, adc_phase_a, adc_phase_b, rotor_angle, output ready);
endinterface

interface pcpl_out_if
  import pcpl_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] direct_current;
  logic signed [OUT_W-1:0] quadrature_current;

  modport source (output valid, direct_current, quadrature_current, input ready);
  modport sink   (input valid, direct_current, quadrature_current, output ready);
endinterface

interface pcpl_cfg_if
  import pcpl_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/pcpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcpl_ctrl
// Sequencer: accepts a beat, walks the twelve multiply-accumulate steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pcpl_ctrl
  import pcpl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pcpl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [3:0] LAST_STEP = 4'd12;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  pcpl_op_t   op;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // state, step and output valid
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd.capture   = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.op        = op;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_nxt    = 4'd0;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 4'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // step program
  always_comb begin
    op.issue  = (state_r == S_RUN);
    op.a_sel  = A_IA;
    op.b_sel  = B_SCALE;
    op.acc_op = ACC_LOAD;
    op.wb_dst = WB_NONE;
    case (step_r)
      4'd0: begin
        op.a_sel = A_DIFF_A; op.b_sel = B_SCALE;
        op.acc_op = ACC_LOAD; op.wb_dst = WB_IA;
      end
      4'd1: begin
        op.a_sel = A_DIFF_B; op.b_sel = B_SCALE;
        op.acc_op = ACC_LOAD; op.wb_dst = WB_IB;
      end
      4'd2: begin
        op.a_sel = A_IA; op.b_sel = B_INV; op.acc_op = ACC_LOAD_RND;
      end
      4'd3: begin
        op.a_sel = A_IB; op.b_sel = B_TWOINV;
        op.acc_op = ACC_ADD; op.wb_dst = WB_BETA;
      end
      4'd4: begin
        op.a_sel = A_IA; op.b_sel = B_COS; op.acc_op = ACC_LOAD_RND;
      end
      4'd5: begin
        op.a_sel = A_BETA; op.b_sel = B_SIN;
        op.acc_op = ACC_ADD; op.wb_dst = WB_D;
      end
      4'd6: begin
        op.a_sel = A_BETA; op.b_sel = B_COS; op.acc_op = ACC_LOAD_RND;
      end
      4'd7: begin
        op.a_sel = A_IA; op.b_sel = B_SIN;
        op.acc_op = ACC_SUB; op.wb_dst = WB_Q;
      end
      4'd8: begin
        op.a_sel = A_FD; op.b_sel = B_OLD; op.acc_op = ACC_LOAD_RND;
      end
      4'd9: begin
        op.a_sel = A_D; op.b_sel = B_NEW;
        op.acc_op = ACC_ADD; op.wb_dst = WB_FD;
      end
      4'd10: begin
        op.a_sel = A_FQ; op.b_sel = B_OLD; op.acc_op = ACC_LOAD_RND;
      end
      4'd11: begin
        op.a_sel = A_Q; op.b_sel = B_NEW;
        op.acc_op = ACC_ADD; op.wb_dst = WB_FQ;
      end
      default: begin
        // last step only drains the pipeline
        op.issue = 1'b0;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/pcpl_datapath.sv @@
// ----------------------------------------------------------------------------
// pcpl_datapath
// Configuration registers, sine lookup, one shared multiplier with an
// accumulator, working registers and the output register.
// ----------------------------------------------------------------------------
module pcpl_datapath
  import pcpl_pkg::*;
#(
  parameter int ADC_BITS         = ADC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int CURRENT_WIDTH    = CURRENT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pcpl_cmd_t               cmd,
  input  pcpl_cfg_wr_t            cfg_wr,
  input  logic [ADC_BITS-1:0]     adc_phase_a,
  input  logic [ADC_BITS-1:0]     adc_phase_b,
  input  logic [ANGLE_W-1:0]      rotor_angle,
  output logic signed [OUT_W-1:0] direct_current,
  output logic signed [OUT_W-1:0] quadrature_current
);

  localparam int CW    = CURRENT_WIDTH;
  localparam int AW    = (CW + 1 > ADC_BITS + 1) ? CW + 1 : ADC_BITS + 1;
  localparam int PW    = AW + COEF_W;
  localparam int ACW   = PW + 1;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int SCL_W = 15 + IDX_W;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned TBL_DIV = 64'd4 * SINE_TABLE_DEPTH;

  localparam logic signed [ACW-1:0] CUR_MAX = ACW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [ACW-1:0] CUR_MIN = -CUR_MAX - ACW'(1);
  localparam logic signed [ACW-1:0] RND_HALF = ACW'(16384);

  // quarter-wave sine entry, Q30 Taylor series up to x^15
  function automatic logic [15:0] table_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    x    = (64'(2 * i + 1) * PI_Q30) / TBL_DIV;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    e = ($unsigned(sum) + 64'd16384) >> 15;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[15:0];
  endfunction

  function automatic logic [SINE_TABLE_DEPTH-1:0][15:0] build_table();
    logic [SINE_TABLE_DEPTH-1:0][15:0] t;
    for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t[i] = table_entry(i);
    end
    return t;
  endfunction

  localparam logic [SINE_TABLE_DEPTH-1:0][15:0] SINE_TBL = build_table();

  function automatic logic signed [CW-1:0] sat_cur(input logic signed [ACW-1:0] v);
    if (v > CUR_MAX) begin
      return CUR_MAX[CW-1:0];
    end
    if (v < CUR_MIN) begin
      return CUR_MIN[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] to_field(input logic signed [CW-1:0] v);
    logic signed [CW+OUT_W-1:0] e;
    e = (CW + OUT_W)'(v);
    return e[OUT_W-1:0];
  endfunction

  logic [BIAS_W-1:0]       bias_r;
  logic [SCALE_W-1:0]      scale_r;
  logic [ADC_BITS-1:0]     adc_a_r;
  logic [ADC_BITS-1:0]     adc_b_r;
  logic [ANGLE_W-1:0]      angle_r;
  logic signed [15:0]      sin_r;
  logic signed [15:0]      cos_r;
  logic signed [CW-1:0]    ia_r;
  logic signed [CW-1:0]    ib_r;
  logic signed [CW:0]      beta_r;
  logic signed [CW-1:0]    d_r;
  logic signed [CW-1:0]    q_r;
  logic signed [CW-1:0]    fd_r;
  logic signed [CW-1:0]    fq_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACW-1:0]   acc_r;
  pcpl_op_t                op_d_r;
  logic signed [OUT_W-1:0] out_d_r;
  logic signed [OUT_W-1:0] out_q_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r  <= BIAS_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_wr.we) begin
      if (cfg_wr.index == REG_BIAS_COUNTS) begin
        bias_r <= cfg_wr.data[BIAS_W-1:0];
      end else if (cfg_wr.index == REG_AMPS_PER_COUNT) begin
        scale_r <= cfg_wr.data[SCALE_W-1:0];
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      adc_a_r <= adc_phase_a;
      adc_b_r <= adc_phase_b;
      angle_r <= rotor_angle;
    end
  end

  // sine and cosine lookup, cosine is one quadrant ahead
  logic [SCL_W-1:0] angle_scaled;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_mir;
  logic [1:0]       quad_s;
  logic [1:0]       quad_c;
  logic [15:0]      sin_raw;
  logic [15:0]      cos_raw;

  always_comb begin
    angle_scaled = SCL_W'(angle_r[13:0]) * SCL_W'(SINE_TABLE_DEPTH);
    idx          = angle_scaled[14 +: IDX_W];
    idx_mir      = IDX_W'(SINE_TABLE_DEPTH - 1) - idx;
    quad_s       = angle_r[15:14];
    quad_c       = quad_s + 2'd1;
    sin_raw      = SINE_TBL[quad_s[0] ? idx_mir : idx];
    cos_raw      = SINE_TBL[quad_c[0] ? idx_mir : idx];
  end

  always_ff @(posedge clk) begin
    sin_r <= quad_s[1] ? -$signed(sin_raw) : $signed(sin_raw);
    cos_r <= quad_c[1] ? -$signed(cos_raw) : $signed(cos_raw);
  end

  // operand select
  logic signed [ADC_BITS:0]   diff_a;
  logic signed [ADC_BITS:0]   diff_b;
  logic signed [ADC_BITS:0]   bias_ext;
  logic signed [AW-1:0]       a_op;
  logic signed [COEF_W-1:0]   b_op;

  always_comb begin
    bias_ext = $signed({1'b0, ADC_BITS'(bias_r)});
    diff_a   = $signed({1'b0, adc_a_r}) - bias_ext;
    diff_b   = $signed({1'b0, adc_b_r}) - bias_ext;
    case (cmd.op.a_sel)
      A_DIFF_A: a_op = AW'(diff_a);
      A_DIFF_B: a_op = AW'(diff_b);
      A_IA:     a_op = AW'(ia_r);
      A_IB:     a_op = AW'(ib_r);
      A_BETA:   a_op = AW'(beta_r);
      A_D:      a_op = AW'(d_r);
      A_Q:      a_op = AW'(q_r);
      A_FD:     a_op = AW'(fd_r);
      A_FQ:     a_op = AW'(fq_r);
      default:  a_op = '0;
    endcase
    case (cmd.op.b_sel)
      B_SCALE:  b_op = $signed({1'b0, scale_r});
      B_INV:    b_op = INV_SQRT3_Q15;
      B_TWOINV: b_op = TWO_INV_SQRT3_Q15;
      B_COS:    b_op = COEF_W'(cos_r);
      B_SIN:    b_op = COEF_W'(sin_r);
      B_OLD:    b_op = LPF_OLD_Q15;
      B_NEW:    b_op = LPF_NEW_Q15;
      default:  b_op = '0;
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
    op_d_r <= cmd.op;
  end

  // accumulate and finish
  logic signed [ACW-1:0] acc_sum;
  logic signed [ACW-1:0] sh8;
  logic signed [ACW-1:0] sh15;

  always_comb begin
    case (op_d_r.acc_op)
      ACC_LOAD:     acc_sum = ACW'(prod_r);
      ACC_LOAD_RND: acc_sum = RND_HALF + ACW'(prod_r);
      ACC_ADD:      acc_sum = acc_r + ACW'(prod_r);
      ACC_SUB:      acc_sum = acc_r - ACW'(prod_r);
      default:      acc_sum = ACW'(prod_r);
    endcase
    sh8  = acc_sum >>> 8;
    sh15 = acc_sum >>> 15;
  end

  always_ff @(posedge clk) begin
    if (op_d_r.issue) begin
      acc_r <= acc_sum;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (op_d_r.issue) begin
      case (op_d_r.wb_dst)
        WB_IA:   ia_r   <= sat_cur(sh8);
        WB_IB:   ib_r   <= sat_cur(sh8);
        WB_BETA: beta_r <= sh15[CW:0];
        WB_D:    d_r    <= sat_cur(sh15);
        WB_Q:    q_r    <= sat_cur(sh15);
        default: begin
        end
      endcase
    end
  end

  // filter memories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r <= '0;
      fq_r <= '0;
    end else if (op_d_r.issue) begin
      if (op_d_r.wb_dst == WB_FD) begin
        fd_r <= sat_cur(sh15);
      end
      if (op_d_r.wb_dst == WB_FQ) begin
        fq_r <= sat_cur(sh15);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_d_r <= to_field(fd_r);
      out_q_r <= to_field(fq_r);
    end
  end

  assign direct_current     = out_d_r;
  assign quadrature_current = out_q_r;

endmodule

@@ hdl/phase_current_clarke_park_lpf.sv @@
// ----------------------------------------------------------------------------
// phase_current_clarke_park_lpf
// Two-shunt phase current front end: scaling, Clarke, Park and low-pass.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one beat per PWM period: two raw phase samples and the
//   electrical angle. out_chan returns one beat per input beat with the
//   filtered d and q currents in Q12 amperes. cfg_chan writes bias_counts
//   (index 0) and amps_per_count (index 1); it is always ready and is to be
//   used only while no beat is in flight. Writes to other indexes are ignored.
//   Sequencing: the twelve products go through the single shared multiplier
//   and accumulator one per cycle; the next input beat is accepted only after
//   the previous result has been handed to the output register.
//   Stall: the output register holds the result until taken; the next input
//   beat is accepted meanwhile, and its result waits in the sequencer until
//   the output register frees up.
//   Reset: registers return to bias 2048 and scale 256, both filter memories
//   clear to zero and no result is pending.
// ----------------------------------------------------------------------------
module phase_current_clarke_park_lpf
  import pcpl_pkg::*;
#(
  parameter int ADC_BITS         = ADC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int CURRENT_WIDTH    = CURRENT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pcpl_in_if.sink      in_chan,
  pcpl_out_if.source   out_chan,
  pcpl_cfg_if.sink     cfg_chan
);

  pcpl_cmd_t    cmd;
  pcpl_cfg_wr_t cfg_wr;

  // configuration writes are taken at once
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr.we      = cfg_chan.valid;
  assign cfg_wr.index   = cfg_chan.index;
  assign cfg_wr.data    = cfg_chan.data;

  // sequencer
  pcpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // arithmetic
  pcpl_datapath #(
    .ADC_BITS         (ADC_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .CURRENT_WIDTH    (CURRENT_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_wr             (cfg_wr),
    .adc_phase_a        (in_chan.adc_phase_a),
    .adc_phase_b        (in_chan.adc_phase_b),
    .rotor_angle        (in_chan.rotor_angle),
    .direct_current     (out_chan.direct_current),
    .quadrature_current (out_chan.quadrature_current)
  );

endmodule

@@ dv/tb_phase_current_clarke_park_lpf.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phase_current_clarke_park_lpf
// Self-checking bench for the two-shunt current front end. A walked table of
// corner beats and register writes comes first, then about 800 random beats
// over several bias and scale settings and three idle patterns. Every beat is
// run through a bit-true model of the scaling, Clarke, Park and low-pass path
// and the filtered d/q currents are checked in order against the DUT.
// ----------------------------------------------------------------------------
module tb_phase_current_clarke_park_lpf;
  import pcpl_pkg::*;

  localparam int ADC_W        = ADC_BITS_DEF;
  localparam int SINE_DEPTH   = SINE_TABLE_DEPTH_DEF;
  localparam int ADC_MAX      = (1 << ADC_W) - 1;
  localparam int SEG_BEATS    = 100;
  localparam int NUM_SEGS     = 8;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // indexes outside the register map, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  localparam longint K_INV_SQRT3  = INV_SQRT3_Q15;
  localparam longint K_2INV_SQRT3 = TWO_INV_SQRT3_Q15;
  localparam longint K_LPF_OLD    = LPF_OLD_Q15;
  localparam longint K_LPF_NEW    = LPF_NEW_Q15;

  typedef struct packed {
    logic signed [OUT_W-1:0] d;
    logic signed [OUT_W-1:0] q;
  } dq_pair_t;

  typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   wdata;
    logic [ADC_W-1:0]        a;
    logic [ADC_W-1:0]        b;
    logic [ANGLE_W-1:0]      ang;
    bit                      typed;
    logic signed [OUT_W-1:0] exp_d;
    logic signed [OUT_W-1:0] exp_q;
  } stim_row_t;

  localparam int N_DIR = 30;

  // kind, index, data, phase a, phase b, angle, typed, d, q
  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_BEAT, 0, 0, 2048, 2048,     0, 1, 0, 0},
    '{ROW_BEAT, 0, 0, 2048, 2048, 16384, 1, 0, 0},
    '{ROW_BEAT, 0, 0, 2048, 2048, 65535, 1, 0, 0},
    '{ROW_BEAT, 0, 0, 4095,    0,     0, 0, 0, 0},
    '{ROW_BEAT, 0, 0,    0, 4095, 16383, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095, 4095, 16384, 0, 0, 0},
    '{ROW_BEAT, 0, 0,    0,    0, 32768, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095, 2048, 49152, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 2048,    0, 65535, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 3000, 1000,  8192, 0, 0, 0},
    '{ROW_REG, REG_AMPS_PER_COUNT, 16'hFFFF, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095, 4095,  8192, 0, 0, 0},
    '{ROW_BEAT, 0, 0,    0,    0, 40960, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095,    0, 24576, 0, 0, 0},
    '{ROW_REG, REG_BIAS_COUNTS, 16'd4095, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, 0,    0,    0,     0, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095, 4095, 57344, 0, 0, 0},
    '{ROW_REG, REG_BIAS_COUNTS, 16'hF000, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_AMPS_PER_COUNT, 16'd0, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095, 4095, 12345, 0, 0, 0},
    '{ROW_REG, REG_UNMAPPED_LO, 16'h1234, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_UNMAPPED_HI, 16'hFFFF, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_AMPS_PER_COUNT, 16'd1, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 4095,    0, 32767, 0, 0, 0},
    '{ROW_BEAT, 0, 0,    1, 4094, 32769, 0, 0, 0},
    '{ROW_REG, REG_BIAS_COUNTS, 16'd2048, 0, 0, 0, 0, 0, 0},
    '{ROW_REG, REG_AMPS_PER_COUNT, 16'd256, 0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 2049, 2047,     1, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 2047, 2049, 65534, 0, 0, 0},
    '{ROW_BEAT, 0, 0, 2048, 2048, 49151, 0, 0, 0}
  };

  logic clk;
  logic rst_n;

  pcpl_in_if #(.ADC_BITS(ADC_W)) in_if ();
  pcpl_out_if                    out_if ();
  pcpl_cfg_if                    cfg_if ();

  phase_current_clarke_park_lpf DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // model state and register copies
  logic [15:0]         sine_lut [SINE_DEPTH];
  longint              filt_d;
  longint              filt_q;
  logic [BIAS_W-1:0]   bias_reg;
  logic [SCALE_W-1:0]  scale_reg;

  dq_pair_t dq_pending [$];

  int fail_count;
  int beats_sent;
  int results_seen;
  int reg_writes;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_ask;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // quarter-wave sine table, Q30 Taylor series to x^15
  initial begin : fill_sine
    longint unsigned x, x2, term, e;
    longint          acc;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x = (64'(2 * i + 1) * PI_Q30) / 64'(4 * SINE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      e = (64'(acc) + 64'd16384) >> 15;
      sine_lut[i] = (e > 64'd32767) ? 16'd32767 : e[15:0];
    end
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint rnd_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint phase_amps(logic [ADC_W-1:0] sample);
    longint diff;
    diff = longint'(sample) - longint'(bias_reg);
    return sat16((diff * longint'(scale_reg)) >>> 8);
  endfunction

  function automatic longint lut_sine(logic [ANGLE_W-1:0] ang);
    int unsigned idx;
    longint      v;
    idx = (int'(ang[13:0]) * SINE_DEPTH) >> 14;
    if (idx >= SINE_DEPTH) idx = SINE_DEPTH - 1;
    if (ang[14]) idx = SINE_DEPTH - 1 - idx;
    v = longint'(sine_lut[idx]);
    return ang[15] ? -v : v;
  endfunction

  // scaling, clarke, park and filter; advances the filter memories
  function automatic dq_pair_t predict_filtered(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b,
                                                logic [ANGLE_W-1:0] ang);
    longint   ia, ib, s, c, beta, d, q;
    dq_pair_t r;
    ia = phase_amps(a);
    ib = phase_amps(b);
    s = lut_sine(ang);
    c = lut_sine(ang + 16'd16384);
    beta = rnd_q15(ia * K_INV_SQRT3 + ib * K_2INV_SQRT3);
    d = sat16(rnd_q15(ia * c + beta * s));
    q = sat16(rnd_q15(beta * c - ia * s));
    filt_d = sat16(rnd_q15(filt_d * K_LPF_OLD + d * K_LPF_NEW));
    filt_q = sat16(rnd_q15(filt_q * K_LPF_OLD + q * K_LPF_NEW));
    r.d = filt_d[15:0];
    r.q = filt_q[15:0];
    return r;
  endfunction

  task automatic note_failure(string what, logic [15:0] want, logic [15:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what,
               $signed(want), $signed(got));
  endtask

  // offer one input beat, record the prediction when it is taken
  task automatic send_beat(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b,
                           logic [ANGLE_W-1:0] ang, bit typed, dq_pair_t typed_res);
    dq_pair_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.adc_phase_a <= a;
    in_if.adc_phase_b <= b;
    in_if.rotor_angle <= ang;
    do @(posedge clk); while (!in_if.ready);
    res = predict_filtered(a, b, ang);
    dq_pending.push_back(typed ? typed_res : res);
    beats_sent++;
  endtask

  // stop offering and let every pending result drain
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (dq_pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register write beat
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_BIAS_COUNTS) bias_reg = data[BIAS_W-1:0];
    else if (idx == REG_AMPS_PER_COUNT) scale_reg = data[SCALE_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // result side: random back-pressure, long stall on request, in-order check
  initial begin : result_sink
    dq_pair_t want;
    int       stall_seen;
    int       hold_left;
    stall_seen = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        results_seen++;
        if (dq_pending.size() == 0) begin
          note_failure("result with nothing pending", 16'd0, out_if.direct_current);
        end else begin
          want = dq_pending.pop_front();
          if (out_if.direct_current !== want.d)
            note_failure("direct_current", want.d, out_if.direct_current);
          if (out_if.quadrature_current !== want.q)
            note_failure("quadrature_current", want.q, out_if.quadrature_current);
        end
      end
      if (stall_seen != stall_ask) begin
        stall_seen = stall_ask;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [ADC_W-1:0]      a, b;
    logic [ANGLE_W-1:0]    ang, sweep_ang, sweep_step;
    logic [CFG_DATA_W-1:0] seg_bias, seg_scale;
    dq_pair_t              typed_res;
    int                    pick, span, lo, hi;

    fail_count = 0;
    beats_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    stall_ask = 0;
    src_idle_pct = 21;
    snk_idle_pct = 52;
    filt_d = 0;
    filt_q = 0;
    bias_reg = BIAS_RESET;
    scale_reg = SCALE_RESET;
    sweep_ang = '0;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.adc_phase_a = '0;
    in_if.adc_phase_b = '0;
    in_if.rotor_angle = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[r].idx, dir_rows[r].wdata);
      end else begin
        typed_res.d = dir_rows[r].exp_d;
        typed_res.q = dir_rows[r].exp_q;
        send_beat(dir_rows[r].a, dir_rows[r].b, dir_rows[r].ang, dir_rows[r].typed,
                  typed_res);
      end
    end

    // random segments, each with its own register setting
    typed_res = '0;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      if (seg < 3) begin
        src_idle_pct = 21;
        snk_idle_pct = 52;
      end else if (seg < 6) begin
        src_idle_pct = 52;
        snk_idle_pct = 21;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (seg)
        0: begin seg_bias = 16'd2048; seg_scale = 16'd256; end
        1: begin seg_bias = 16'd0; seg_scale = 16'hFFFF; end
        2: begin seg_bias = 16'd4095; seg_scale = 16'd1; end
        4: begin seg_bias = 16'd2048; seg_scale = 16'hFFFF; end
        5: begin seg_bias = 16'($urandom_range(65535)); seg_scale = 16'($urandom_range(1023)); end
        6: begin seg_bias = 16'd2048; seg_scale = 16'd256; end
        default: begin
          seg_bias = 16'($urandom_range(65535));
          seg_scale = 16'($urandom_range(65535));
        end
      endcase
      write_reg(REG_BIAS_COUNTS, seg_bias);
      write_reg(REG_AMPS_PER_COUNT, seg_scale);
      sweep_step = 16'($urandom_range(3000, 1));

      for (int i = 0; i < SEG_BEATS; i++) begin
        // long output stall while beats keep coming
        if ((seg == 1 || seg == 4) && i == 20) stall_ask++;
        // let everything drain mid-segment
        if ((seg == 2 || seg == 5) && i == 50) wait_idle();
        pick = $urandom_range(99);
        if (pick < 70) begin
          // rotating angle, currents around the bias point
          sweep_ang = sweep_ang + sweep_step;
          ang = sweep_ang;
          span = $urandom_range(700, 1);
          lo = (int'(bias_reg) > span) ? int'(bias_reg) - span : 0;
          hi = (int'(bias_reg) + span > ADC_MAX) ? ADC_MAX : int'(bias_reg) + span;
          a = ADC_W'($urandom_range(hi, lo));
          b = ADC_W'($urandom_range(hi, lo));
        end else if (pick < 85) begin
          a = ADC_W'($urandom_range(ADC_MAX));
          b = ADC_W'($urandom_range(ADC_MAX));
          ang = ANGLE_W'($urandom_range(65535));
        end else begin
          // quadrant edges with full-scale samples
          ang = {2'($urandom_range(3)), $urandom_range(1) ? 14'h3FFF : 14'h0000};
          a = $urandom_range(1) ? ADC_W'(ADC_MAX) : '0;
          b = $urandom_range(1) ? ADC_W'(ADC_MAX) : '0;
        end
        send_beat(a, b, ang, 1'b0, typed_res);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d beats and %0d results over %0d register writes,", beats_sent,
             results_seen, reg_writes);
    $display("with saturating scales, quadrant edges, long output stall and drain pauses");
    if (fail_count == 0 && dq_pending.size() == 0) begin
      $display("tb_phase_current_clarke_park_lpf: clean");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, dq_pending.size());
      $display("tb_phase_current_clarke_park_lpf: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results pending", dq_pending.size());
    $display("tb_phase_current_clarke_park_lpf: errors");
    $finish;
  end

endmodule
